@@ rtl/core/throttle_to_pwm_duty_ramp_assert.svh @@
// Assertion macros for the throttle to PWM duty ramp block.
`ifndef THROTTLE_TO_PWM_DUTY_RAMP_ASSERT_SVH
`define THROTTLE_TO_PWM_DUTY_RAMP_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define TPDR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define TPDR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tpdr_pkg.sv @@
// Shared types, constants and register map of the throttle duty ramp.
`timescale 1ns / 1ps
package tpdr_pkg;

  // Parameter defaults
  localparam int DUTY_BITS_DEF = 16;
  localparam int ADC_BITS_DEF  = 12;

  // Fixed field widths
  localparam int SAMPLE_W = 12;
  localparam int PHASE_W  = 16;
  localparam int DUTY_W   = 16;
  localparam int MV_W     = 12;
  localparam int STEP_W   = 8;

  // Full scale of the throttle voltage in mV
  localparam int MV_FULL = 3300;

  // Register reset values
  localparam int RST_RUN_THR  = 500;
  localparam int RST_STARTUP  = 200;
  localparam int RST_MAX      = 1000;
  localparam int RST_PROTECT  = 400;
  localparam int RST_STALL    = 4500;
  localparam int RST_STEP     = 10;

  // Divider retires this many quotient bits per cycle
  localparam int DIV_BITS_PER_CYC = 2;

  // APB port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  typedef enum logic [2:0] {
    REG_RUN_THR  = 3'd0,
    REG_STARTUP  = 3'd1,
    REG_MAX      = 3'd2,
    REG_PROTECT  = 3'd3,
    REG_STALL    = 3'd4,
    REG_STEP     = 3'd5
  } reg_idx_e;

  // Configuration as seen by the sequencer; duty fields are zero extended
  typedef struct packed {
    logic [MV_W-1:0]    run_threshold_mv;
    logic [DUTY_W-1:0]  base_duty;
    logic [DUTY_W-1:0]  max_duty;
    logic [DUTY_W-1:0]  protect_duty;
    logic [PHASE_W-1:0] stall_phase_limit;
    logic [STEP_W-1:0]  ramp_step;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MV_MUL,
    ST_MV_DIV,
    ST_MV_WAIT,
    ST_SPAN_MUL,
    ST_SPAN_DIV,
    ST_SPAN_WAIT,
    ST_TGT,
    ST_SLEW,
    ST_OUT
  } ctrl_state_e;

endpackage

@@ rtl/core/tpdr_if.sv @@
// Request channels of the throttle duty ramp: tick input and duty result.
`timescale 1ns / 1ps
interface tpdr_in_if;
  import tpdr_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] throttle_sample;
  logic [PHASE_W-1:0]  phase_time;

  modport source (output valid, output throttle_sample, output phase_time, input ready);
  modport sink   (input valid, input throttle_sample, input phase_time, output ready);
endinterface

interface tpdr_out_if;
  import tpdr_pkg::*;
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_now;
  logic              duty_changed;
  logic [DUTY_W-1:0] target_duty;
  logic              drive_off;
  logic              start_request;

  modport source (output valid, output duty_now, output duty_changed, output target_duty,
                  output drive_off, output start_request, input ready);
  modport sink   (input valid, input duty_now, input duty_changed, input target_duty,
                  input drive_off, input start_request, output ready);
endinterface

@@ rtl/core/tpdr_regs.sv @@
// APB configuration registers of the throttle duty ramp.
`timescale 1ns / 1ps
module tpdr_regs #(
  parameter int DUTY_BITS = tpdr_pkg::DUTY_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpdr_pkg::APB_AW-1:0] paddr,
  input  logic [tpdr_pkg::APB_DW-1:0] pwdata,
  output logic [tpdr_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output tpdr_pkg::cfg_t              cfg_o
);
  import tpdr_pkg::*;

  logic [MV_W-1:0]      thr_q;
  logic [DUTY_BITS-1:0] startup_q;
  logic [DUTY_BITS-1:0] max_q;
  logic [DUTY_BITS-1:0] protect_q;
  logic [PHASE_W-1:0]   stall_q;
  logic [STEP_W-1:0]    step_q;
  reg_idx_e             idx;
  logic                 wr_en;

  assign idx    = reg_idx_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= MV_W'(RST_RUN_THR);
      startup_q <= DUTY_BITS'(RST_STARTUP);
      max_q     <= DUTY_BITS'(RST_MAX);
      protect_q <= DUTY_BITS'(RST_PROTECT);
      stall_q   <= PHASE_W'(RST_STALL);
      step_q    <= STEP_W'(RST_STEP);
    end else if (wr_en) begin
      case (idx)
        REG_RUN_THR: thr_q     <= pwdata[MV_W-1:0];
        REG_STARTUP: startup_q <= pwdata[DUTY_BITS-1:0];
        REG_MAX:     max_q     <= pwdata[DUTY_BITS-1:0];
        REG_PROTECT: protect_q <= pwdata[DUTY_BITS-1:0];
        REG_STALL:   stall_q   <= pwdata[PHASE_W-1:0];
        REG_STEP:    step_q    <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_RUN_THR: prdata = APB_DW'(thr_q);
      REG_STARTUP: prdata = APB_DW'(startup_q);
      REG_MAX:     prdata = APB_DW'(max_q);
      REG_PROTECT: prdata = APB_DW'(protect_q);
      REG_STALL:   prdata = APB_DW'(stall_q);
      REG_STEP:    prdata = APB_DW'(step_q);
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.run_threshold_mv  = thr_q;
  assign cfg_o.base_duty         = DUTY_W'(startup_q);
  assign cfg_o.max_duty          = DUTY_W'(max_q);
  assign cfg_o.protect_duty      = DUTY_W'(protect_q);
  assign cfg_o.stall_phase_limit = stall_q;
  assign cfg_o.ramp_step         = step_q;

endmodule

@@ rtl/core/tpdr_div.sv @@
// Shared iterative restoring divider, two quotient bits per cycle.
`timescale 1ns / 1ps
module tpdr_div #(
  parameter int NUM_W = 28,
  parameter int DEN_W = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);
  import tpdr_pkg::*;

  localparam int ITERS = NUM_W / DIV_BITS_PER_CYC;
  localparam int CNT_W = $clog2(ITERS + 1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q;

  // Retire DIV_BITS_PER_CYC quotient bits: shift in, compare, subtract
  always_comb begin
    logic [DEN_W:0] trial;
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < DIV_BITS_PER_CYC; i++) begin
      trial = {rem_d, quo_d[NUM_W-1]};
      quo_d = {quo_d[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        trial    = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[DEN_W-1:0];
    end
  end

  // Iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ITERS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

@@ rtl/core/tpdr_ctrl.sv @@
// Sequencer and datapath: scaling, run/restart logic, target and slew.
`timescale 1ns / 1ps
module tpdr_ctrl #(
  parameter int DUTY_BITS = tpdr_pkg::DUTY_BITS_DEF,
  parameter int ADC_BITS  = tpdr_pkg::ADC_BITS_DEF,
  parameter int NUM_W     = 28,
  parameter int DEN_W     = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tpdr_pkg::cfg_t   cfg_i,
  tpdr_in_if.sink          in_ch,
  tpdr_out_if.source       out_ch,
  output logic             div_start_o,
  output logic [NUM_W-1:0] div_num_o,
  output logic [DEN_W-1:0] div_den_o,
  input  logic             div_done_i,
  input  logic [NUM_W-1:0] div_quo_i
);
  import tpdr_pkg::*;

  localparam int MUL_A_W = (ADC_BITS > DUTY_BITS) ? ADC_BITS : DUTY_BITS;
  localparam int PROD_W  = MUL_A_W + MV_W;
  localparam int SUM_W   = DUTY_BITS + 1;
  localparam int SX_W    = SAMPLE_W + ADC_BITS;
  localparam logic [ADC_BITS-1:0] ADC_FULL = {ADC_BITS{1'b1}};

  ctrl_state_e state_q, state_d;

  // Per-tick working registers
  logic [ADC_BITS-1:0]  sample_q;
  logic [PHASE_W-1:0]   phase_q;
  logic [NUM_W-1:0]     prod_q;
  logic [MV_W-1:0]      mv_q;
  logic [DUTY_BITS-1:0] add_q;
  logic [DUTY_BITS-1:0] tgt_q;
  logic                 drive_off_q;
  logic                 start_req_q;
  logic [DUTY_BITS-1:0] res_duty_q;
  logic                 res_chg_q;

  // Persistent state
  logic                 armed_q;
  logic [DUTY_BITS-1:0] duty_q;

  // Output register
  logic                 out_valid_q;
  logic [DUTY_W-1:0]    out_duty_q;
  logic                 out_chg_q;
  logic [DUTY_W-1:0]    out_tgt_q;
  logic                 out_off_q;
  logic                 out_start_q;

  logic [SX_W-1:0]      sample_x;
  logic [DUTY_BITS-1:0] startup, max_lim, protect;
  logic                 above, below, span_div_need, out_free;
  logic [MV_W-1:0]      span;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MV_W-1:0]      mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic                 use_span;
  logic [DUTY_BITS-1:0] tgt_d;
  logic [DUTY_BITS-1:0] duty_d;
  logic                 chg_d;

  assign sample_x = SX_W'(in_ch.throttle_sample);
  assign startup  = cfg_i.base_duty[DUTY_BITS-1:0];
  assign max_lim  = cfg_i.max_duty[DUTY_BITS-1:0];
  assign protect  = cfg_i.protect_duty[DUTY_BITS-1:0];

  // Threshold compare and span above threshold
  assign above         = mv_q > cfg_i.run_threshold_mv;
  assign below         = mv_q < cfg_i.run_threshold_mv;
  assign span          = mv_q - cfg_i.run_threshold_mv;
  assign span_div_need = above && (max_lim > startup);
  assign out_free      = !out_valid_q || out_ch.ready;

  // Shared multiplier: sample * full scale, then duty range * span
  assign mul_a = use_span ? MUL_A_W'(max_lim - startup) : MUL_A_W'(sample_q);
  assign mul_b = use_span ? span : MV_W'(MV_FULL);
  assign mul_p = mul_a * mul_b;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_ch.valid) state_d = ST_MV_MUL;
      ST_MV_MUL:    state_d = ST_MV_DIV;
      ST_MV_DIV:    state_d = ST_MV_WAIT;
      ST_MV_WAIT:   if (div_done_i) state_d = ST_SPAN_MUL;
      ST_SPAN_MUL:  state_d = span_div_need ? ST_SPAN_DIV : ST_TGT;
      ST_SPAN_DIV:  state_d = ST_SPAN_WAIT;
      ST_SPAN_WAIT: if (div_done_i) state_d = ST_TGT;
      ST_TGT:       state_d = ST_SLEW;
      ST_SLEW:      state_d = ST_OUT;
      ST_OUT:       if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // State decoded controls
  always_comb begin
    in_ch.ready = (state_q == ST_IDLE);
    use_span    = (state_q == ST_SPAN_MUL);
    div_start_o = (state_q == ST_MV_DIV) || (state_q == ST_SPAN_DIV);
    div_num_o   = prod_q;
    div_den_o   = (state_q == ST_SPAN_DIV) ?
                  DEN_W'(MV_W'(MV_FULL) - cfg_i.run_threshold_mv) : DEN_W'(ADC_FULL);
  end

  // Target: base plus scaled span, clamp to max, cap near stall
  always_comb begin
    logic [SUM_W-1:0] sum;
    sum   = SUM_W'(startup) + SUM_W'(add_q);
    tgt_d = (sum > SUM_W'(max_lim)) ? max_lim : sum[DUTY_BITS-1:0];
    if ((phase_q > cfg_i.stall_phase_limit) && (tgt_d > protect)) begin
      tgt_d = protect;
    end
  end

  // Slew one step toward the target, single count when close
  always_comb begin
    logic [STEP_W-1:0] step;
    logic [SUM_W-1:0]  up_sum;
    logic [SUM_W-1:0]  dn_lim;
    step   = (cfg_i.ramp_step == '0) ? STEP_W'(1) : cfg_i.ramp_step;
    up_sum = SUM_W'(duty_q) + SUM_W'(step);
    dn_lim = SUM_W'(tgt_q) + SUM_W'(step);
    duty_d = duty_q;
    chg_d  = 1'b0;
    if (duty_q < tgt_q) begin
      chg_d  = 1'b1;
      duty_d = (up_sum < SUM_W'(tgt_q)) ? up_sum[DUTY_BITS-1:0]
                                        : duty_q + DUTY_BITS'(1);
    end else if (duty_q > tgt_q) begin
      chg_d  = 1'b1;
      duty_d = (SUM_W'(duty_q) > dn_lim) ? duty_q - DUTY_BITS'(step)
                                         : duty_q - DUTY_BITS'(1);
    end
  end

  // Control and persistent state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= 1'b1;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_SPAN_MUL) begin
        if (below) begin
          armed_q <= 1'b1;
        end else if (above) begin
          armed_q <= 1'b0;
        end
      end
      if (state_q == ST_SLEW) begin
        duty_q <= duty_d;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sample_q <= sample_x[ADC_BITS-1:0];
        phase_q  <= in_ch.phase_time;
      end
      ST_MV_MUL:  prod_q <= NUM_W'(mul_p);
      ST_MV_WAIT: mv_q   <= div_quo_i[MV_W-1:0];
      ST_SPAN_MUL: begin
        prod_q      <= NUM_W'(mul_p);
        drive_off_q <= below;
        start_req_q <= above && armed_q;
        add_q       <= '0;
      end
      ST_SPAN_WAIT: add_q <= div_quo_i[DUTY_BITS-1:0];
      ST_TGT:       tgt_q <= tgt_d;
      ST_SLEW: begin
        res_duty_q <= duty_d;
        res_chg_q  <= chg_d;
      end
      ST_OUT: begin
        if (out_free) begin
          out_duty_q  <= DUTY_W'(res_duty_q);
          out_chg_q   <= res_chg_q;
          out_tgt_q   <= DUTY_W'(tgt_q);
          out_off_q   <= drive_off_q;
          out_start_q <= start_req_q;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.duty_now      = out_duty_q;
  assign out_ch.duty_changed  = out_chg_q;
  assign out_ch.target_duty   = out_tgt_q;
  assign out_ch.drive_off     = out_off_q;
  assign out_ch.start_request = out_start_q;

endmodule

@@ rtl/core/throttle_to_pwm_duty_ramp.sv @@
// Top level of the throttle to PWM duty ramp.
// Sequence: a request is scaled to mV on the shared divider (NUM_W = 28 by default),
//   then its span above the threshold is divided too, unless the throttle is at or
//   below the threshold or max_duty <= base_duty; target, slew and output follow.
// Requests: one at a time, taken only in idle once the last result is registered; the
//   divider and multiplier are shared by both scaling steps of one request.
// Reset: registers take their defaults, restart armed, duty 0, no result pending.
`timescale 1ns / 1ps
module throttle_to_pwm_duty_ramp #(
  parameter int DUTY_BITS = tpdr_pkg::DUTY_BITS_DEF,
  parameter int ADC_BITS  = tpdr_pkg::ADC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  tpdr_in_if.sink                     in_i,
  tpdr_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpdr_pkg::APB_AW-1:0] paddr,
  input  logic [tpdr_pkg::APB_DW-1:0] pwdata,
  output logic [tpdr_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import tpdr_pkg::*;

  localparam int MUL_A_W = (ADC_BITS > DUTY_BITS) ? ADC_BITS : DUTY_BITS;
  localparam int NUM_RAW = MUL_A_W + MV_W;
  localparam int NUM_W   = NUM_RAW + (NUM_RAW % DIV_BITS_PER_CYC);
  localparam int DEN_W   = (ADC_BITS > MV_W) ? ADC_BITS : MV_W;

  cfg_t             cfg;
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  tpdr_regs #(
    .DUTY_BITS(DUTY_BITS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  tpdr_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  tpdr_ctrl #(
    .DUTY_BITS(DUTY_BITS),
    .ADC_BITS (ADC_BITS),
    .NUM_W    (NUM_W),
    .DEN_W    (DEN_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_ch      (in_i),
    .out_ch     (out_o),
    .div_start_o(div_start),
    .div_num_o  (div_num),
    .div_den_o  (div_den),
    .div_done_i (div_done),
    .div_quo_i  (div_quo)
  );

endmodule

@@ rtl/core/tpdr_checker.sv @@
// Port-level checks of the throttle duty ramp, bound to the top level.
`timescale 1ns / 1ps
`include "throttle_to_pwm_duty_ramp_assert.svh"
module tpdr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [tpdr_pkg::DUTY_W-1:0] out_duty_now_i,
  input logic                        out_duty_changed_i,
  input logic [tpdr_pkg::DUTY_W-1:0] out_target_duty_i,
  input logic                        out_drive_off_i,
  input logic                        out_start_request_i
);
  import tpdr_pkg::*;

  // One request at a time: the sequencer leaves idle on a request
  `TPDR_ASSERT_NEXT(a_busy_after_req, in_valid_i && in_ready_i, !in_ready_i, "input ready held after a request was taken")

  // Stop and start can never be asked for in the same tick
  `TPDR_ASSERT(a_stop_start_excl, !out_valid_i || !(out_drive_off_i && out_start_request_i), "drive off and start request both set")

  // An unchanged duty means the duty already sits on the target
  `TPDR_ASSERT(a_hold_on_target, !out_valid_i || out_duty_changed_i || (out_duty_now_i == out_target_duty_i), "duty held while off target")

  // A stalled result stays put
  `TPDR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_duty_now_i) && $stable(out_target_duty_i), "result changed while stalled")

endmodule

bind throttle_to_pwm_duty_ramp tpdr_checker u_tpdr_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_duty_now_i     (out_o.duty_now),
  .out_duty_changed_i (out_o.duty_changed),
  .out_target_duty_i  (out_o.target_duty),
  .out_drive_off_i    (out_o.drive_off),
  .out_start_request_i(out_o.start_request)
);
